// ----- src/mt32_pkg.sv -----
`timescale 1ns / 1ps

package mt32_pkg;

   // table geometry
   localparam int STATE_WORDS  = 624;
   localparam int SHIFT_OFFSET = 397;
   localparam int ADDR_W       = $clog2(STATE_WORDS);

   // front queue depth (tokens waiting for the engine)
   localparam int QUEUE_DEPTH  = 2;
   localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [31:0]        word_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam word_type SEED_RESET = 32'd5489;
   localparam word_type INIT_MULT  = 32'd1812433253;
   localparam word_type TWIST_XOR  = 32'h9908_B0DF;
   localparam word_type TEMPER_B   = 32'h9D2C_5680;
   localparam word_type TEMPER_C   = 32'hEFC6_0000;

   localparam addr_type  LAST_ADDR  = addr_type'(STATE_WORDS - 1);
   localparam addr_type  NXT_START  = addr_type'(1);
   localparam addr_type  FAR_START  = addr_type'(SHIFT_OFFSET);
   localparam count_type QUEUE_FULL = count_type'(QUEUE_DEPTH);

   // engine sequencer states
   typedef enum logic [2:0] {
      ST_FILL  = 3'b001,
      ST_PRIME = 3'b010,
      ST_RUN   = 3'b100
   } eng_state_type;

   // table index + 1, wrapping at the end of the table
   function automatic addr_type addr_inc(input addr_type a);
      return (a == LAST_ADDR) ? '0 : a + addr_type'(1);
   endfunction

   // seeding recurrence: word k from word k-1
   function automatic word_type fill_next(input word_type prev, input addr_type k);
      word_type mixed;
      mixed = prev ^ (prev >> 30);
      return word_type'(INIT_MULT * mixed) + word_type'(k);
   endfunction

   // one-word twist
   function automatic word_type twist(input word_type cur, input word_type nxt,
                                      input word_type far);
      word_type x;
      word_type xa;
      x  = {cur[31], nxt[30:0]};
      xa = x >> 1;
      if (x[0]) begin
         xa = xa ^ TWIST_XOR;
      end
      return far ^ xa;
   endfunction

   function automatic word_type temper(input word_type y_in);
      word_type y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ----- src/mt32_front.sv -----
`timescale 1ns / 1ps

module mt32_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_draw,
   output logic q_avail,
   input  logic q_pop
);
   import mt32_pkg::*;

   count_type count_ff;
   count_type count_in;
   logic      push;

   // draw == 0 beats are taken and dropped here
   assign req_ready = (count_ff != QUEUE_FULL);
   assign push      = req_valid && req_ready && req_draw;
   assign q_avail   = (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + count_type'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_FULL)
      else $error("front queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_avail)
      else $error("pop from empty front queue");

endmodule

// ----- src/mt32_engine.sv -----
`timescale 1ns / 1ps

module mt32_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  mt32_pkg::word_type csr_seed,
   input  logic               q_avail,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mt32_pkg::word_type rsp_random_word
);
   import mt32_pkg::*;

   word_type      mem [STATE_WORDS];

   eng_state_type state_ff, state_in;
   addr_type      fill_k_ff, fill_k_in;
   word_type      prev_ff, prev_in;
   word_type      cur_ff, cur_in;
   addr_type      pos_ff, pos_in;
   addr_type      rdn_addr_ff, rdn_addr_in;
   addr_type      rdf_addr_ff, rdf_addr_in;
   word_type      rd_nxt_ff, rd_far_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_word_ff, rsp_word_in;

   logic          fire;
   logic          rd_en;
   logic          wr_en;
   addr_type      wr_addr;
   word_type      wr_data;
   word_type      fill_val;
   word_type      new_word;

   assign fire     = (state_ff == ST_RUN) && q_avail && (!rsp_valid_ff || rsp_ready);
   assign q_pop    = fire;
   assign new_word = twist(cur_ff, rd_nxt_ff, rd_far_ff);
   assign fill_val = (fill_k_ff == '0) ? prev_ff : fill_next(prev_ff, fill_k_ff);

   // single write port shared by the fill and the twist
   assign wr_en   = (state_ff == ST_FILL) || fire;
   assign wr_addr = (state_ff == ST_FILL) ? fill_k_ff : pos_ff;
   assign wr_data = (state_ff == ST_FILL) ? fill_val : new_word;
   assign rd_en   = (state_ff == ST_PRIME) || fire;

   always_comb begin
      state_in     = state_ff;
      fill_k_in    = fill_k_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      rdn_addr_in  = rdn_addr_ff;
      rdf_addr_in  = rdf_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_FILL: begin
            prev_in = fill_val;
            if (fill_k_ff == LAST_ADDR) begin
               state_in = ST_PRIME;
            end else begin
               fill_k_in = fill_k_ff + addr_type'(1);
            end
         end
         ST_PRIME: begin
            rdn_addr_in = addr_inc(rdn_addr_ff);
            rdf_addr_in = addr_inc(rdf_addr_ff);
            state_in    = ST_RUN;
         end
         ST_RUN: begin
            if (fire) begin
               cur_in       = rd_nxt_ff;
               pos_in       = addr_inc(pos_ff);
               rdn_addr_in  = addr_inc(rdn_addr_ff);
               rdf_addr_in  = addr_inc(rdf_addr_ff);
               rsp_valid_in = 1'b1;
               rsp_word_in  = temper(new_word);
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase

      // seed write restarts the fill from word 0
      if (csr_wr_en) begin
         state_in    = ST_FILL;
         fill_k_in   = '0;
         prev_in     = csr_seed;
         cur_in      = csr_seed;
         pos_in      = '0;
         rdn_addr_in = NXT_START;
         rdf_addr_in = FAR_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_k_ff    <= '0;
         prev_ff      <= SEED_RESET;
         cur_ff       <= SEED_RESET;
         pos_ff       <= '0;
         rdn_addr_ff  <= NXT_START;
         rdf_addr_ff  <= FAR_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_k_ff    <= fill_k_in;
         prev_ff      <= prev_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         rdn_addr_ff  <= rdn_addr_in;
         rdf_addr_ff  <= rdf_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // state table: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_nxt_ff <= mem[rdn_addr_ff];
         rd_far_ff <= mem[rdf_addr_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rdn_addr_ff != pos_ff) && (rdf_addr_ff != pos_ff))
      else $error("prefetch address meets twist write address");

   a_prime_after_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRIME) |-> $past(state_ff == ST_FILL) && $past(fill_k_ff == LAST_ADDR))
      else $error("prime entered before fill completed");

   a_fire_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (fire && !csr_wr_en) |=> rsp_valid_ff)
      else $error("twist issued without result beat");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("stalled result beat changed");

endmodule

// ----- src/mersenne_twister_32.sv -----
`timescale 1ns / 1ps

// MT19937 32-bit generator. Each req beat with req_draw set yields one tempered
// 32-bit word on the rsp channel, in standard MT19937 order; a req beat with
// req_draw clear is taken and produces nothing. Steady throughput is one word
// per clock while rsp is not stalled: the engine twists a single table word
// per draw, writing word i through the write port of the 624-word state
// memory from word i, held in a register, and words i+1 and i+397, which the
// two read ports fetched one draw ahead. Draws wait in the front queue until
// the engine takes them; the tempered result is registered onto rsp. After
// reset and every csr_seed write, the table is refilled from the seed at one
// word per clock, then a prime state prefetches the first operands; draws
// accepted meanwhile (up to two) wait in the front queue. Reset seed is 5489.
// Write csr_seed only while no draw is outstanding.
module mersenne_twister_32 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_draw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mt32_pkg::word_type rsp_random_word,
   input  logic               csr_wr_en,
   input  mt32_pkg::word_type csr_seed
);
   import mt32_pkg::*;

   logic q_avail;   // at least one draw waiting for the engine
   logic q_pop;     // engine takes a draw this cycle

   // front: accepts beats, drops empty requests, queues draws
   mt32_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_draw  (req_draw),
      .q_avail   (q_avail),
      .q_pop     (q_pop)
   );

   // back: seed fill, per-word twist, tempering, result register
   mt32_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_seed        (csr_seed),
      .q_avail         (q_avail),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_word (rsp_random_word)
   );

endmodule
